[hdl/mpi_pkg.sv]
// Shared types, constants and helpers of the multi-motor PI speed controller.
`default_nettype none

package mpi_pkg;

   // Motor table
   localparam int MOTORS  = 4;
   localparam int MOTOR_W = 2;
   localparam int SLOT_W  = $clog2((MOTORS > 1) ? MOTORS : 2);

   // Channel widths
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   // Request kinds carried on req_tuser
   localparam logic ACTION_TICK     = 1'b0;
   localparam logic ACTION_SETPOINT = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLOSED_LOOP = 3'd0,
      CSR_PROP_GAIN   = 3'd1,
      CSR_INTEG_GAIN  = 3'd2,
      CSR_ACCUM_LIMIT = 3'd3,
      CSR_DEADZONE    = 3'd4,
      CSR_MAX_COMMAND = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_FORWARD  = 2'd0,
      DIR_BACKWARD = 2'd1,
      DIR_BRAKE    = 2'd2
   } dir_type;

   // Reset values and limits
   localparam logic [6:0]  DEADZONE_RST    = 7'd15;
   localparam logic [6:0]  MAX_COMMAND_RST = 7'd40;
   localparam logic [30:0] ACCUM_LIMIT_RST = '1;
   localparam logic [6:0]  PWM_MAX         = 7'd100;
   localparam int          SETPOINT_BAND   = 10;

   // Integrator increment: gain * |error| * dt / (16 * 1000), capped at 2^40
   localparam int MS_PER_S       = 1000;
   localparam int TIME_DIV       = 16 * MS_PER_S;
   localparam int TIME_DIV_SHIFT = 7;
   localparam int DIV_CONST      = TIME_DIV / (1 << TIME_DIV_SHIFT);
   localparam int INC_CAP_SHIFT  = 40;
   localparam int INC_W          = INC_CAP_SHIFT + 1;
   localparam int PROD_W         = 73;
   localparam logic [INC_W-1:0]  INC_CAP = INC_W'(1) << INC_CAP_SHIFT;
   localparam logic [PROD_W-1:0] INC_SAT_PROD = PROD_W'(TIME_DIV) << INC_CAP_SHIFT;

   // Constant divider by DIV_CONST
   localparam int DIV_W             = 48;
   localparam int DIV_BITS_PER_STEP = 8;
   localparam int DIV_STEPS         = DIV_W / DIV_BITS_PER_STEP;
   localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
   localparam int REM_W             = $clog2(DIV_CONST);
   localparam logic [REM_W:0] DIV_CONST_V = (REM_W + 1)'(DIV_CONST);

   typedef struct packed {
      logic signed [15:0] target;
      logic signed [31:0] integ;
      logic [31:0]        last_time;
      logic [1:0]         dir;
   } motor_state_type;

   typedef struct packed {
      logic        closed_loop;
      logic [23:0] prop_gain;
      logic [23:0] integ_gain;
      logic [30:0] accum_limit;
      logic [6:0]  deadzone;
      logic [6:0]  max_command;
   } cfg_type;

   typedef struct packed {
      logic            rd_en;
      logic            wr_en;
      logic [SLOT_W-1:0] addr;
      motor_state_type wdata;
   } ram_req_type;

   // Fold a motor index into the table
   function automatic logic [SLOT_W-1:0] slot_of(input logic [MOTOR_W-1:0] m);
      logic [7:0] v;
      v = 8'(m);
      for (int i = 0; i < (1 << MOTOR_W) - 1; i++) begin
         if (v >= 8'(MOTORS)) begin
            v = v - 8'(MOTORS);
         end
      end
      return SLOT_W'(v);
   endfunction

endpackage

`default_nettype wire

[hdl/mpi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/mpi_div.sv]
// Iterative divider by a fixed constant, eight quotient bits per cycle.
`default_nettype none

module mpi_div
   import mpi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     work_ff, work_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Restoring division: dividend bits shift out the top, quotient bits in the bottom
   always_comb begin
      logic [REM_W:0] trial;
      logic           fits;
      rem_in  = rem_ff;
      work_in = work_ff;
      for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
         trial   = {rem_in, work_in[DIV_W-1]};
         fits    = (trial >= DIV_CONST_V);
         work_in = {work_in[DIV_W-2:0], fits};
         rem_in  = fits ? REM_W'(trial - DIV_CONST_V) : trial[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         work_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

`default_nettype wire

[hdl/mpi_core.sv]
// Control sequencer and fixed-point PI datapath working on the per-motor state RAM.
`default_nettype none

module mpi_core
   import mpi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  cfg_type               cfg,
   output ram_req_type           ram_req,
   input  motor_state_type       ram_rdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_READ  = 10'b00_0000_0010,
      S_EVAL  = 10'b00_0000_0100,
      S_MUL   = 10'b00_0000_1000,
      S_SUM   = 10'b00_0001_0000,
      S_DIV   = 10'b00_0010_0000,
      S_ACC   = 10'b00_0100_0000,
      S_CMD   = 10'b00_1000_0000,
      S_CLAMP = 10'b01_0000_0000,
      S_EMIT  = 10'b10_0000_0000
   } state_type;

   localparam logic [1:0] MUL_PROP  = 2'd0;
   localparam logic [1:0] MUL_INTEG = 2'd1;
   localparam logic [1:0] MUL_DT_LO = 2'd2;
   localparam logic [1:0] MUL_DT_HI = 2'd3;

   state_type state_ff, state_in;

   // Request capture
   logic                action_ff;
   logic [MOTOR_W-1:0]  motor_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic signed [15:0]  setpoint_ff;
   logic [31:0]         stamp_ff;
   logic [14:0]         speed_ff;
   logic [6:0]          olp_ff;
   logic                accept;

   logic [MOTORS-1:0]   valid_ff;
   motor_state_type     st_ff;

   // Datapath registers
   logic [1:0]          dir_new_ff;
   logic                neg_ff;
   logic [16:0]         mag_ff;
   logic [31:0]         dt_ff;
   logic [1:0]          mul_cnt_ff;
   logic [40:0]         pmag_ff;
   logic [40:0]         a_ff;
   logic [55:0]         plo_ff;
   logic [48:0]         phi_ff;
   logic                sat_ff;
   logic [INC_W-1:0]    inc_ff;
   logic signed [31:0]  integ_new_ff;
   logic signed [39:0]  cmd_ff;
   logic [6:0]          res_pwm_ff;
   logic [1:0]          res_dir_ff;

   // Output register
   logic                rsp_valid_ff;
   logic [MOTOR_W-1:0]  out_motor_ff;
   logic [6:0]          out_pwm_ff;
   logic [1:0]          out_dir_ff;
   logic                emit_load;

   // Evaluation signals
   logic signed [16:0]  sp_diff;
   logic                sp_clear;
   logic                sp_pos, sp_neg, agree;
   logic signed [15:0]  sp_eff;
   logic [1:0]          dir_eval;
   logic [16:0]         sp_ext, abs_sp;
   logic [17:0]         err;
   logic [16:0]         mag_eval;
   logic [6:0]          olp_sat;

   logic [23:0]         mul_a;
   logic [31:0]         mul_b;
   logic [55:0]         mul_p;

   logic [PROD_W-1:0]   prod_full;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_q;

   logic signed [42:0]  integ_ext, inc_ext, acc_sum, lim_pos, lim_neg, acc_clamp;
   logic signed [39:0]  pcmd, integ_ext40;
   logic signed [40:0]  cmd_ext, dz_ext, cmd_dz, mc_ext, cmd_sat;
   logic [6:0]          mc7;
   motor_state_type     wr_state;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // ---------------- request evaluation ----------------
   always_comb begin
      sp_diff  = 17'(setpoint_ff) - 17'(st_ff.target);
      sp_clear = (sp_diff > 17'sd10) || (sp_diff < -17'sd10);

      sp_pos = (st_ff.target > 16'sd0);
      sp_neg = (st_ff.target < 16'sd0);
      agree  = (sp_pos && st_ff.dir == DIR_FORWARD) || (sp_neg && st_ff.dir == DIR_BACKWARD);
      sp_eff   = st_ff.target;
      dir_eval = st_ff.dir;
      if (!agree) begin
         if (speed_ff == 15'd0) begin
            dir_eval = sp_neg ? DIR_BACKWARD : DIR_FORWARD;
         end else begin
            // Moving against the target: brake toward zero
            dir_eval = DIR_BRAKE;
            sp_eff   = 16'sd0;
         end
      end
      sp_ext   = {sp_eff[15], sp_eff};
      abs_sp   = sp_ext[16] ? (~sp_ext + 17'd1) : sp_ext;
      err      = {1'b0, abs_sp} - {3'b000, speed_ff};
      mag_eval = err[17] ? 17'(~err + 18'd1) : err[16:0];

      olp_sat = (olp_ff > PWM_MAX) ? PWM_MAX : olp_ff;
   end

   // ---------------- shared multiplier ----------------
   always_comb begin
      case (mul_cnt_ff)
         MUL_PROP: begin
            mul_a = cfg.prop_gain;
            mul_b = 32'(mag_ff);
         end
         MUL_INTEG: begin
            mul_a = cfg.integ_gain;
            mul_b = 32'(mag_ff);
         end
         MUL_DT_LO: begin
            mul_a = a_ff[23:0];
            mul_b = dt_ff;
         end
         MUL_DT_HI: begin
            mul_a = 24'(a_ff[40:24]);
            mul_b = dt_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = 56'(mul_a) * 56'(mul_b);
   end

   // ---------------- increment and integrator ----------------
   assign prod_full = {phi_ff, 24'd0} + PROD_W'(plo_ff);
   assign div_start = (state_ff == S_SUM);

   mpi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_W'(prod_full >> TIME_DIV_SHIFT)),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      integ_ext = {{11{st_ff.integ[31]}}, st_ff.integ};
      inc_ext   = {2'b00, inc_ff};
      acc_sum   = neg_ff ? (integ_ext - inc_ext) : (integ_ext + inc_ext);
      lim_pos   = {12'd0, cfg.accum_limit};
      lim_neg   = -lim_pos;
      if (acc_sum > lim_pos) begin
         acc_clamp = lim_pos;
      end else if (acc_sum < lim_neg) begin
         acc_clamp = lim_neg;
      end else begin
         acc_clamp = acc_sum;
      end
   end

   // ---------------- command shaping ----------------
   always_comb begin
      pcmd        = {3'b000, pmag_ff[40:4]};
      if (neg_ff) begin
         pcmd = -pcmd;
      end
      integ_ext40 = {{8{integ_new_ff[31]}}, integ_new_ff};

      cmd_ext = {cmd_ff[39], cmd_ff};
      dz_ext  = {18'd0, cfg.deadzone, 16'd0};
      if (cmd_ext > 41'sd0) begin
         cmd_dz = cmd_ext + dz_ext;
      end else if (cmd_ext < 41'sd0) begin
         cmd_dz = cmd_ext - dz_ext;
      end else begin
         cmd_dz = cmd_ext;
      end
      mc7    = (cfg.max_command > PWM_MAX) ? PWM_MAX : cfg.max_command;
      mc_ext = {18'd0, mc7, 16'd0};
      if (cmd_dz > mc_ext) begin
         cmd_sat = mc_ext;
      end else if (cmd_dz < 41'sd0) begin
         cmd_sat = '0;
      end else begin
         cmd_sat = cmd_dz;
      end
   end

   // ---------------- state RAM access ----------------
   always_comb begin
      wr_state = st_ff;
      if (state_ff == S_EVAL) begin
         wr_state.target = setpoint_ff;
         if (sp_clear) begin
            wr_state.integ = '0;
         end
      end else begin
         wr_state.integ     = integ_new_ff;
         wr_state.last_time = stamp_ff;
         wr_state.dir       = dir_new_ff;
      end
      ram_req.rd_en = accept;
      ram_req.wr_en = ((state_ff == S_EVAL) && (action_ff == ACTION_SETPOINT)) ||
                      (state_ff == S_CLAMP);
      ram_req.addr  = accept ? slot_of(req_tdata[1:0]) : slot_ff;
      ram_req.wdata = wr_state;
   end

   // ---------------- sequencer ----------------
   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_READ;
         S_READ:  state_in = S_EVAL;
         S_EVAL: begin
            if (action_ff == ACTION_SETPOINT) begin
               state_in = S_IDLE;
            end else if (!cfg.closed_loop) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL:   if (mul_cnt_ff == MUL_DT_HI) state_in = S_SUM;
         S_SUM:   state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_ACC;
         S_ACC:   state_in = S_CMD;
         S_CMD:   state_in = S_CLAMP;
         S_CLAMP: state_in = S_EMIT;
         S_EMIT:  if (emit_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         mul_cnt_ff   <= MUL_PROP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ram_req.wr_en) begin
            valid_ff[slot_ff] <= 1'b1;
         end
         if (state_ff == S_MUL) begin
            mul_cnt_ff <= mul_cnt_ff + 2'd1;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req_tuser;
         motor_ff    <= req_tdata[1:0];
         slot_ff     <= slot_of(req_tdata[1:0]);
         setpoint_ff <= req_tdata[17:2];
         stamp_ff    <= req_tdata[49:18];
         speed_ff    <= req_tdata[64:50];
         olp_ff      <= req_tdata[71:65];
      end
      if (state_ff == S_READ) begin
         // An entry never written reads as the reset state
         st_ff <= valid_ff[slot_ff] ? ram_rdata : '0;
      end
      if (state_ff == S_EVAL) begin
         dir_new_ff <= dir_eval;
         neg_ff     <= err[17];
         mag_ff     <= mag_eval;
         dt_ff      <= stamp_ff - st_ff.last_time;
         res_pwm_ff <= olp_sat;
         res_dir_ff <= st_ff.dir;
      end
      if (state_ff == S_MUL) begin
         case (mul_cnt_ff)
            MUL_PROP:  pmag_ff <= mul_p[40:0];
            MUL_INTEG: a_ff    <= mul_p[40:0];
            MUL_DT_LO: plo_ff  <= mul_p;
            MUL_DT_HI: phi_ff  <= mul_p[48:0];
            default:   a_ff    <= a_ff;
         endcase
      end
      if (state_ff == S_SUM) begin
         sat_ff <= (prod_full >= INC_SAT_PROD);
      end
      if ((state_ff == S_DIV) && div_done) begin
         inc_ff <= sat_ff ? INC_CAP : div_q[INC_W-1:0];
      end
      if (state_ff == S_ACC) begin
         integ_new_ff <= acc_clamp[31:0];
      end
      if (state_ff == S_CMD) begin
         cmd_ff <= pcmd + integ_ext40;
      end
      if (state_ff == S_CLAMP) begin
         res_pwm_ff <= cmd_sat[22:16];
         res_dir_ff <= dir_new_ff;
      end
      if (emit_load) begin
         out_motor_ff <= motor_ff;
         out_pwm_ff   <= res_pwm_ff;
         out_dir_ff   <= res_dir_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, out_dir_ff, out_pwm_ff, out_motor_ff};

endmodule

`default_nettype wire

[hdl/motor_pi_speed_controller.sv]
// Multi-motor PI speed controller: top level with configuration registers and state RAM.
//
// Usage:
//   req channel (req_tvalid/req_tready/req_tdata/req_tuser) takes one request at a time.
//   req_tuser is the request kind: 0 runs a control tick, 1 stores a new setpoint.
//   A tick returns one result on the rsp channel; a setpoint request returns nothing.
//   Per-motor state (target, integrator, last timestamp, direction) lives in a RAM
//   with a registered read; each setpoint request and closed-loop tick reads its
//   entry, updates it and writes it back before the next request is taken; an
//   open-loop tick only reads it. A closed-loop tick makes four passes through the
//   shared 24x32 multiplier and divides the integrator increment by 16000; an
//   open-loop tick and a setpoint request use neither.
//   csr channel writes a register (index on csr_index); csr_ready is
//   always high. Write registers only while no request is outstanding.
//   Reset clears all per-motor state to zero/forward and loads the register defaults.
//   The result sits in an output register; while the receiver stalls, the next
//   request is still processed up to its own result, which waits for the register.
`default_nettype none

module motor_pi_speed_controller
   import mpi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // motor[1:0], setpoint[17:2], timestamp[49:18], measured_speed[64:50],
   // open_loop_percent[71:65]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // action[0]
   input  logic                   req_tuser,
   // motor_out[1:0], pwm_percent[8:2], drive_direction[10:9], zero fill above
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type         cfg_ff;
   ram_req_type     ram_req;
   motor_state_type ram_rdata;
   logic [$bits(motor_state_type)-1:0] ram_rd_bits;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.closed_loop <= 1'b1;
         cfg_ff.prop_gain   <= '0;
         cfg_ff.integ_gain  <= '0;
         cfg_ff.accum_limit <= ACCUM_LIMIT_RST;
         cfg_ff.deadzone    <= DEADZONE_RST;
         cfg_ff.max_command <= MAX_COMMAND_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLOSED_LOOP: cfg_ff.closed_loop <= csr_data[0];
            CSR_PROP_GAIN:   cfg_ff.prop_gain   <= csr_data[23:0];
            CSR_INTEG_GAIN:  cfg_ff.integ_gain  <= csr_data[23:0];
            CSR_ACCUM_LIMIT: cfg_ff.accum_limit <= csr_data[30:0];
            CSR_DEADZONE:    cfg_ff.deadzone    <= csr_data[6:0];
            CSR_MAX_COMMAND: cfg_ff.max_command <= csr_data[6:0];
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   mpi_ram #(
      .WIDTH ($bits(motor_state_type)),
      .DEPTH (MOTORS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.addr),
      .wr_data (ram_req.wdata),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rdata = ram_rd_bits;

   mpi_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_one_request_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_ram_single_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.rd_en && ram_req.wr_en))
      else $error("state RAM read and write in the same cycle");

   a_pwm_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:2] <= PWM_MAX)
      else $error("pwm percent above full scale");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the multi-motor PI speed controller: directed plan, then random phases.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpi_pkg::*;

   localparam int IDLE_LIMIT    = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 25;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 53;
   localparam int SPEED_MAX     = 16767;
   localparam int SETPOINT_MAX  = 16767;

   typedef struct {
      logic               action;
      logic [1:0]         motor;
      logic signed [15:0] setpoint;
      logic [31:0]        stamp;
      logic [14:0]        speed;
      logic [6:0]         open_pct;
   } req_t;

   typedef struct {
      logic [1:0] motor;
      logic [6:0] pwm;
      dir_type    dir;
   } drive_t;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_t;

   typedef struct {
      row_kind_t     kind;
      csr_index_type sel;
      logic [30:0]   val;
      req_t          item;
      bit            typed;
      logic [6:0]    pwm;
      dir_type       dir;
   } plan_row_t;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   motor_pi_speed_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Controller copy: registers and per-motor state
   cfg_type            ctl_cfg;
   logic signed [15:0] tgt_tbl   [MOTORS];
   logic signed [31:0] integ_tbl [MOTORS];
   logic [31:0]        stamp_tbl [MOTORS];
   dir_type            dir_tbl   [MOTORS];

   drive_t    drive_due_q[$];
   plan_row_t plan_q[$];
   int        mismatches = 0;

   // Typed expectation for the request on the bus, set with the request
   bit         typed_on = 1'b0;
   logic [6:0] typed_pwm = '0;
   dir_type    typed_dir = DIR_FORWARD;

   bit         long_hold_go = 1'b0;

   // Stimulus shaping: per-motor target and clock as the generator sees them
   int          gen_tgt [MOTORS];
   logic [31:0] gen_now [MOTORS];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void store_setpoint(input req_t r);
      int slot;
      int gap;
      slot = r.motor % MOTORS;
      gap = int'(r.setpoint) - int'(tgt_tbl[slot]);
      // a large jump in target restarts the integrator
      if (gap > SETPOINT_BAND || gap < -SETPOINT_BAND) integ_tbl[slot] = '0;
      tgt_tbl[slot] = r.setpoint;
   endfunction

   function automatic drive_t next_drive(input req_t r);
      int                slot;
      longint            sp, err, pcmd, incr, acc, lim, cmd, dz, mc;
      longint unsigned   mag;
      bit                neg;
      logic [31:0]       dt;
      logic [79:0]       prod, inc80;
      drive_t            d;
      slot = r.motor % MOTORS;
      d.motor = r.motor;
      if (!ctl_cfg.closed_loop) begin
         d.pwm = (r.open_pct > PWM_MAX) ? PWM_MAX : r.open_pct;
         d.dir = dir_tbl[slot];
         return d;
      end
      sp = tgt_tbl[slot];
      if (!((sp > 0 && dir_tbl[slot] == DIR_FORWARD) ||
            (sp < 0 && dir_tbl[slot] == DIR_BACKWARD))) begin
         if (r.speed == 0) begin
            dir_tbl[slot] = (sp < 0) ? DIR_BACKWARD : DIR_FORWARD;
         end else begin
            // moving the wrong way: brake toward zero
            sp = 0;
            dir_tbl[slot] = DIR_BRAKE;
         end
      end
      err = ((sp < 0) ? -sp : sp) - longint'(r.speed);
      neg = (err < 0);
      mag = neg ? -err : err;
      dt = r.stamp - stamp_tbl[slot];
      pcmd = longint'((64'(ctl_cfg.prop_gain) * mag) >> 4);
      if (neg) pcmd = -pcmd;
      prod = 80'(ctl_cfg.integ_gain) * 80'(mag) * 80'(dt);
      inc80 = prod / 80'(TIME_DIV);
      if (inc80 > 80'(INC_CAP)) inc80 = 80'(INC_CAP);
      incr = longint'(inc80[63:0]);
      acc = longint'(integ_tbl[slot]) + (neg ? -incr : incr);
      lim = longint'(ctl_cfg.accum_limit);
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integ_tbl[slot] = 32'(acc);
      cmd = pcmd + acc;
      dz = longint'(ctl_cfg.deadzone) << 16;
      if (cmd > 0) cmd = cmd + dz;
      else if (cmd < 0) cmd = cmd - dz;
      mc = longint'((ctl_cfg.max_command > PWM_MAX) ? PWM_MAX : ctl_cfg.max_command) << 16;
      if (cmd > mc) cmd = mc;
      if (cmd < 0) cmd = 0;
      stamp_tbl[slot] = r.stamp;
      d.pwm = 7'(cmd >>> 16);
      d.dir = dir_tbl[slot];
      return d;
   endfunction

   // Track register writes, accepted requests and drive results
   always @(posedge clock) begin : monitor
      req_t   r;
      drive_t want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOSED_LOOP: ctl_cfg.closed_loop = csr_data[0];
               CSR_PROP_GAIN:   ctl_cfg.prop_gain   = csr_data[23:0];
               CSR_INTEG_GAIN:  ctl_cfg.integ_gain  = csr_data[23:0];
               CSR_ACCUM_LIMIT: ctl_cfg.accum_limit = csr_data[30:0];
               CSR_DEADZONE:    ctl_cfg.deadzone    = csr_data[6:0];
               CSR_MAX_COMMAND: ctl_cfg.max_command = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            r.action   = req_tuser;
            r.motor    = req_tdata[1:0];
            r.setpoint = req_tdata[17:2];
            r.stamp    = req_tdata[49:18];
            r.speed    = req_tdata[64:50];
            r.open_pct = req_tdata[71:65];
            if (r.action == ACTION_SETPOINT) begin
               store_setpoint(r);
            end else begin
               want = next_drive(r);
               if (typed_on) begin
                  want.pwm = typed_pwm;
                  want.dir = typed_dir;
               end
               drive_due_q.push_back(want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (drive_due_q.size() == 0) begin
               mismatches++;
               $display("%0t: drive result %h with no request pending", $time, rsp_tdata);
            end else begin
               want = drive_due_q.pop_front();
               if (rsp_tdata[1:0] !== want.motor) begin
                  mismatches++;
                  $display("%0t: motor_out expected %0d, got %0d",
                           $time, want.motor, rsp_tdata[1:0]);
               end
               if (rsp_tdata[8:2] !== want.pwm) begin
                  mismatches++;
                  $display("%0t: pwm_percent expected %0d, got %0d",
                           $time, want.pwm, rsp_tdata[8:2]);
               end
               if (rsp_tdata[10:9] !== want.dir) begin
                  mismatches++;
                  $display("%0t: drive_direction expected %0d, got %0d",
                           $time, want.dir, rsp_tdata[10:9]);
               end
            end
         end
      end
   end

   // Receiver: cycle through ready patterns, with one long hold-off on request
   initial begin : receiver
      int cyc;
      int mode;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            mode = (cyc / 150) % 4;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ((cyc % 9) < 4);
               default: rsp_tready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("tb: failure");
      $finish;
   end

   function automatic void plan_csr(input csr_index_type sel, input logic [30:0] val);
      plan_row_t s;
      s.kind = ROW_CSR;
      s.sel = sel;
      s.val = val;
      s.typed = 1'b0;
      plan_q.push_back(s);
   endfunction

   function automatic void plan_set(input logic [1:0] m, input int sp);
      plan_row_t s;
      s.kind = ROW_REQ;
      s.item.action = ACTION_SETPOINT;
      s.item.motor = m;
      s.item.setpoint = 16'(sp);
      s.item.stamp = $urandom;
      s.item.speed = $urandom_range(0, SPEED_MAX);
      s.item.open_pct = $urandom_range(0, 100);
      s.typed = 1'b0;
      plan_q.push_back(s);
   endfunction

   function automatic void plan_tick(input logic [1:0] m, input logic [31:0] stamp,
                                     input logic [14:0] speed, input logic [6:0] pct,
                                     input bit typed = 1'b0, input logic [6:0] pwm = '0,
                                     input dir_type dir = DIR_FORWARD);
      plan_row_t s;
      s.kind = ROW_REQ;
      s.item.action = ACTION_TICK;
      s.item.motor = m;
      s.item.setpoint = 16'($urandom);
      s.item.stamp = stamp;
      s.item.speed = speed;
      s.item.open_pct = pct;
      s.typed = typed;
      s.pwm = pwm;
      s.dir = dir;
      plan_q.push_back(s);
   endfunction

   function automatic req_t make_item();
      req_t r;
      int   roll;
      int   m;
      int   v;
      roll = $urandom_range(0, 99);
      m = $urandom_range(0, MOTORS - 1);
      r.action = ACTION_TICK;
      r.motor = m;
      v = int'($urandom_range(0, 2 * SETPOINT_MAX)) - SETPOINT_MAX;
      r.setpoint = 16'(v);
      r.stamp = $urandom;
      r.speed = $urandom_range(0, SPEED_MAX);
      r.open_pct = $urandom_range(0, 100);
      if (roll < 10) begin
         // noise: any field, any kind
         r.action = $urandom_range(0, 1);
      end else if (roll < 25) begin
         r.action = ACTION_SETPOINT;
         if ($urandom_range(0, 1)) begin
            // small step around the current target, across the clearing band
            v = gen_tgt[m] + int'($urandom_range(0, 24)) - 12;
            if (v > SETPOINT_MAX) v = SETPOINT_MAX;
            if (v < -SETPOINT_MAX) v = -SETPOINT_MAX;
            r.setpoint = 16'(v);
         end else if (roll < 18) begin
            v = int'($urandom_range(0, 6000)) - 3000;
            r.setpoint = 16'(v);
         end
      end else begin
         case ($urandom_range(0, 19))
            0:       ;
            1:       gen_now[m] = gen_now[m] + $urandom;
            default: gen_now[m] = gen_now[m] + $urandom_range(1, 20);
         endcase
         r.stamp = gen_now[m];
         if ($urandom_range(0, 4) == 0) begin
            r.speed = '0;
         end else begin
            v = ((gen_tgt[m] < 0) ? -gen_tgt[m] : gen_tgt[m]) +
                int'($urandom_range(0, 100)) - 50;
            if (v < 0) v = 0;
            if (v > SPEED_MAX) v = SPEED_MAX;
            r.speed = 15'(v);
         end
      end
      if (r.action == ACTION_SETPOINT) gen_tgt[m] = r.setpoint;
      else gen_now[m] = r.stamp;
      return r;
   endfunction

   task automatic push_req(input req_t r, input bit typed, input logic [6:0] pwm,
                           input dir_type dir);
      @(negedge clock);
      typed_on = typed;
      typed_pwm = pwm;
      typed_dir = dir;
      req_tvalid <= 1'b1;
      req_tuser <= r.action;
      req_tdata <= {r.open_pct, r.speed, r.stamp, r.setpoint, r.motor};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_req(input int n);
      @(negedge clock) req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Drop valid, wait for every drive result, then let setpoint work finish
   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (drive_due_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [30:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int          burst_left;
      logic [30:0] v;
      req_t        it;
      ctl_cfg = {1'b1, 24'd0, 24'd0, ACCUM_LIMIT_RST, DEADZONE_RST, MAX_COMMAND_RST};
      foreach (tgt_tbl[i]) begin
         tgt_tbl[i] = '0;
         integ_tbl[i] = '0;
         stamp_tbl[i] = '0;
         dir_tbl[i] = DIR_FORWARD;
         gen_tgt[i] = 0;
         gen_now[i] = '0;
      end

      // Reset state: zero targets, stopped motor goes forward, moving one brakes
      plan_tick(0, 0, 0, 0, 1'b1, 0, DIR_FORWARD);
      plan_tick(1, 5, 15'(SPEED_MAX), 100, 1'b1, 0, DIR_BRAKE);
      // Open loop: percent passes through, clipped at 100, stored direction
      plan_csr(CSR_CLOSED_LOOP, 0);
      plan_tick(1, 6, 0, 100, 1'b1, 100, DIR_BRAKE);
      plan_tick(2, 7, 0, 127, 1'b1, 100, DIR_FORWARD);
      plan_tick(3, 8, 0, 0, 1'b1, 0, DIR_FORWARD);
      // Saturating proportional term against the command ceiling
      plan_csr(CSR_CLOSED_LOOP, 1);
      plan_csr(CSR_PROP_GAIN, 31'hFFFFFF);
      plan_set(2, SETPOINT_MAX);
      plan_tick(2, 10, 0, 0, 1'b1, 40, DIR_FORWARD);
      plan_csr(CSR_MAX_COMMAND, 127);
      plan_tick(2, 20, 0, 0, 1'b1, 100, DIR_FORWARD);
      plan_csr(CSR_MAX_COMMAND, 0);
      plan_tick(2, 30, 100, 0, 1'b1, 0, DIR_FORWARD);
      plan_csr(CSR_MAX_COMMAND, 100);
      // Reversal: stopped motor turns backward, moving one brakes
      plan_set(3, -SETPOINT_MAX);
      plan_tick(3, 40, 0, 0, 1'b1, 100, DIR_BACKWARD);
      plan_set(3, 5);
      plan_tick(3, 50, 15'(SPEED_MAX), 0, 1'b1, 0, DIR_BRAKE);
      plan_tick(3, 60, 0, 0);
      // Integrator: saturated increment over a huge interval, band edges
      plan_csr(CSR_PROP_GAIN, 0);
      plan_csr(CSR_INTEG_GAIN, 31'hFFFFFF);
      plan_csr(CSR_DEADZONE, 0);
      plan_tick(3, 32'hFFFFFFFF, 0, 0);
      plan_set(3, 15);
      plan_tick(3, 32'hFFFFFFFF, 40, 0);
      plan_set(3, 26);
      plan_tick(3, 0, 26, 0);
      plan_csr(CSR_ACCUM_LIMIT, 0);
      plan_tick(0, 1000, 300, 0);
      plan_csr(CSR_ACCUM_LIMIT, 31'h7FFFFFFF);
      plan_csr(CSR_DEADZONE, 100);
      plan_csr(CSR_PROP_GAIN, 31'h000800);
      plan_csr(CSR_INTEG_GAIN, 31'h001000);
      plan_set(0, -300);
      plan_tick(0, 1100, 0, 0);
      plan_tick(0, 1101, 250, 0);

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (plan_q[i]) begin
         if (plan_q[i].kind == ROW_CSR) begin
            settle();
            write_csr(plan_q[i].sel, plan_q[i].val);
         end else begin
            push_req(plan_q[i].item, plan_q[i].typed, plan_q[i].pwm, plan_q[i].dir);
         end
      end
      for (int i = 0; i < MOTORS; i++) begin
         gen_tgt[i] = tgt_tbl[i];
         gen_now[i] = stamp_tbl[i];
      end

      burst_left = 0;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_csr(CSR_CLOSED_LOOP, 31'($urandom_range(0, 4) != 0));
         case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 31'hFFFFFF;
            default: v = 31'($urandom & ((32'd1 << $urandom_range(6, 18)) - 1));
         endcase
         write_csr(CSR_PROP_GAIN, v);
         case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 31'hFFFFFF;
            default: v = 31'($urandom & ((32'd1 << $urandom_range(8, 22)) - 1));
         endcase
         write_csr(CSR_INTEG_GAIN, v);
         case ($urandom_range(0, 4))
            0:       v = 31'h7FFFFFFF;
            1:       v = '0;
            default: v = 31'($urandom_range(32'h10000, 32'h320000));
         endcase
         write_csr(CSR_ACCUM_LIMIT, v);
         case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = 31'd100;
            default: v = 31'($urandom_range(0, 30));
         endcase
         write_csr(CSR_DEADZONE, v);
         case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 31'd100;
            default: v = 31'($urandom_range(20, 100));
         endcase
         write_csr(CSR_MAX_COMMAND, v);
         // hold the receiver off while requests keep coming
         if (p == 3) long_hold_go = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               if ($urandom_range(0, 2) != 0) idle_req($urandom_range(1, 15));
            end
            burst_left--;
            it = make_item();
            push_req(it, 1'b0, '0, DIR_FORWARD);
         end
      end

      settle();
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
